>>> sv/plqls_pkg.sv
// Package: shared constants and codes for the lane scheduler.
`default_nettype none
package plqls_pkg;

  localparam int NUM_LANES_DEF  = 3;
  localparam int LANE_DEPTH_DEF = 16;

  localparam int KIND_W      = 3;
  localparam int LANE_PORT_W = 2;

  localparam logic [KIND_W-1:0] PRIO_KIND_RST = 3'd4;

  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage
`default_nettype wire

>>> sv/plqls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plqls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/priority_longest_queue_lane_scheduler.sv
// Top level: priority / longest-queue lane scheduler with ring-buffer RAM.
//
// Command channel: an item (func_i, lane_i, kind_i) is taken on a clock edge
// with start high and busy low. func_i = enqueue appends kind_i to lane
// lane_i; func_i = tick serves one item. Items of the priority kind are held
// as a per-lane count and always leave first; other kinds sit in a per-lane
// ring buffer inside one RAM of NUM_LANES*LANE_DEPTH entries.
// Every accepted beat gives exactly one result beat, marked by result_valid_o
// for one cycle, in the cycle right after acceptance. The next item may be
// started in that same cycle, so the block takes one item per cycle; busy
// stays low. The RAM read on a tick of a normal item is registered; counters
// and pointers live in flops so a tick and a following enqueue never collide
// on the RAM.
// Tick selection: lowest lane with a priority item, else the longest lane
// (ties to the lower lane), found by a compare chain over the lane totals.
// Configuration: cfg_data_i is written to the priority-kind register on a
// cfg_valid_i/cfg_ready_o beat; write it only while no item is in flight.
// Reset clears all counters and pointers and sets the priority kind to 4;
// the RAM is not cleared, as only written entries are ever read.
// The receiver cannot stall: each result is presented once and not held.
`default_nettype none
module priority_longest_queue_lane_scheduler #(
  parameter int NUM_LANES  = plqls_pkg::NUM_LANES_DEF,
  parameter int LANE_DEPTH = plqls_pkg::LANE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               func_i,
  input  wire logic [plqls_pkg::LANE_PORT_W-1:0]  lane_i,
  input  wire logic [plqls_pkg::KIND_W-1:0]       kind_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [plqls_pkg::KIND_W-1:0]       cfg_data_i,
  output logic                                    result_valid_o,
  output logic                                    served_o,
  output logic      [plqls_pkg::LANE_PORT_W-1:0]  served_lane_o,
  output logic      [plqls_pkg::KIND_W-1:0]       served_kind_o,
  output logic                                    dropped_o,
  output logic                                    all_empty_o
);

  localparam int KW      = plqls_pkg::KIND_W;
  localparam int LPW     = plqls_pkg::LANE_PORT_W;
  localparam int LANE_W  = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int CNT_W   = $clog2(LANE_DEPTH + 1);
  localparam int PTR_W   = $clog2(LANE_DEPTH);
  localparam int RAM_D   = NUM_LANES * LANE_DEPTH;
  localparam int ADDR_W  = $clog2(RAM_D);

  logic [KW-1:0]    prio_kind_q;

  logic [CNT_W-1:0] pcnt_q [NUM_LANES];
  logic [CNT_W-1:0] pcnt_d [NUM_LANES];
  logic [CNT_W-1:0] ncnt_q [NUM_LANES];
  logic [CNT_W-1:0] ncnt_d [NUM_LANES];
  logic [PTR_W-1:0] head_q [NUM_LANES];
  logic [PTR_W-1:0] head_d [NUM_LANES];
  logic [CNT_W-1:0] total  [NUM_LANES];

  logic             rv_q, rv_d;
  logic             served_q, served_d;
  logic [LPW-1:0]   slane_q, slane_d;
  logic [KW-1:0]    skind_q, skind_d;
  logic             from_ram_q, from_ram_d;
  logic             dropped_q, dropped_d;
  logic             empty_q, empty_d;
  logic             tick_q, tick_d;

  logic             accept;
  logic [LANE_W-1:0] enq_lane;
  logic             enq_oob;
  logic             prio_found;
  logic [LANE_W-1:0] prio_pick;
  logic [CNT_W-1:0] best;
  logic [LANE_W-1:0] long_pick;
  logic [LANE_W-1:0] pick;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail_pos;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [KW-1:0]     ram_rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign enq_lane    = LANE_W'(lane_i);
  assign enq_oob     = 32'(lane_i) >= NUM_LANES;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      total[i] = pcnt_q[i] + ncnt_q[i];
    end
  end

  // lowest lane with a priority item
  always_comb begin
    prio_found = 1'b0;
    prio_pick  = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (pcnt_q[i] != '0) begin
        prio_found = 1'b1;
        prio_pick  = LANE_W'(i);
      end
    end
  end

  // longest lane, ties to the lower number
  always_comb begin
    best      = '0;
    long_pick = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (total[i] > best) begin
        best      = total[i];
        long_pick = LANE_W'(i);
      end
    end
  end

  assign pick     = prio_found ? prio_pick : long_pick;
  assign tail_sum = (PTR_W+1)'(head_q[enq_lane]) + (PTR_W+1)'(ncnt_q[enq_lane]);
  assign tail_pos = (32'(tail_sum) >= LANE_DEPTH) ?
                    PTR_W'(32'(tail_sum) - LANE_DEPTH) : PTR_W'(tail_sum);

  always_comb begin
    pcnt_d     = pcnt_q;
    ncnt_d     = ncnt_q;
    head_d     = head_q;
    rv_d       = accept;
    served_d   = 1'b0;
    slane_d    = '0;
    skind_d    = '0;
    from_ram_d = 1'b0;
    dropped_d  = 1'b0;
    tick_d     = accept && (func_i == plqls_pkg::FUNC_TICK);
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = ADDR_W'(32'(enq_lane) * LANE_DEPTH + 32'(tail_pos));
    ram_raddr  = ADDR_W'(32'(pick) * LANE_DEPTH + 32'(head_q[pick]));
    if (accept) begin
      if (func_i == plqls_pkg::FUNC_ENQ) begin
        if (enq_oob) begin
          dropped_d = 1'b1;
        end else if (32'(total[enq_lane]) >= LANE_DEPTH) begin
          dropped_d = 1'b1;
        end else if (kind_i == prio_kind_q) begin
          pcnt_d[enq_lane] = pcnt_q[enq_lane] + 1'b1;
        end else begin
          ram_we           = 1'b1;
          ncnt_d[enq_lane] = ncnt_q[enq_lane] + 1'b1;
        end
      end else if (prio_found || best != '0) begin
        served_d = 1'b1;
        slane_d  = LPW'(pick);
        if (pcnt_q[pick] != '0) begin
          pcnt_d[pick] = pcnt_q[pick] - 1'b1;
          skind_d      = prio_kind_q;
        end else begin
          ram_re       = 1'b1;
          from_ram_d   = 1'b1;
          ncnt_d[pick] = ncnt_q[pick] - 1'b1;
          head_d[pick] = (32'(head_q[pick]) == LANE_DEPTH - 1) ? '0 : head_q[pick] + 1'b1;
        end
      end
    end
    empty_d = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (pcnt_d[i] != '0 || ncnt_d[i] != '0) begin
        empty_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_kind_q <= plqls_pkg::PRIO_KIND_RST;
      for (int i = 0; i < NUM_LANES; i++) begin
        pcnt_q[i] <= '0;
        ncnt_q[i] <= '0;
        head_q[i] <= '0;
      end
      rv_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        prio_kind_q <= cfg_data_i;
      end
      pcnt_q <= pcnt_d;
      ncnt_q <= ncnt_d;
      head_q <= head_d;
      rv_q   <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_q   <= served_d;
    slane_q    <= slane_d;
    skind_q    <= skind_d;
    from_ram_q <= from_ram_d;
    dropped_q  <= dropped_d;
    empty_q    <= empty_d;
    tick_q     <= tick_d;
  end

  plqls_ram #(
    .WIDTH (KW),
    .DEPTH (RAM_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (kind_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = rv_q;
  assign served_o       = served_q;
  assign served_lane_o  = slane_q;
  assign served_kind_o  = from_ram_q ? ram_rdata : skind_q;
  assign dropped_o      = dropped_q;
  assign all_empty_o    = empty_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("accepted beat produced no result");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without accepted beat");

  a_serve_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(served_o && dropped_o))
    else $error("served and dropped together");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && tick_q && !served_o) |-> all_empty_o)
    else $error("tick served nothing while lanes held items");

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_chk
    a_lane_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
      32'(pcnt_q[g]) + 32'(ncnt_q[g]) <= LANE_DEPTH)
      else $error("lane overfilled");
  end

endmodule
`default_nettype wire
